### design/thfe_pkg.sv
// Shared constants, types and arithmetic helpers for the terrain height-field evaluator.
package thfe_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ATAN_COUNT  = 24;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = FRAC_BITS + 1;
    // S1..S4, R1, R2, M1..M6, select, N1, N2, square root, D0, dividers, output
    localparam int FIXED_DEPTH = 4 + 8 + 1 + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;

    localparam logic [1:0] SHAPE_CONST    = 2'd0;
    localparam logic [1:0] SHAPE_PLANE    = 2'd1;
    localparam logic [1:0] SHAPE_PERIODIC = 2'd2;

    localparam logic [2:0] REG_SHAPE_MODE  = 3'd0;
    localparam logic [2:0] REG_BASE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SLOPE_X     = 3'd2;
    localparam logic [2:0] REG_SLOPE_Z     = 3'd3;
    localparam logic [2:0] REG_ANCHOR_XZ   = 3'd4;
    localparam logic [2:0] REG_AMPLITUDE   = 3'd5;
    localparam logic [2:0] REG_INV_WL_X    = 3'd6;
    localparam logic [2:0] REG_INV_WL_Z    = 3'd7;

    typedef struct packed {
        logic signed [33:0] pyb;
        logic signed [31:0] fpl;
    } side_t;

    typedef struct packed {
        logic signed [31:0] field;
        logic signed [31:0] gx;
        logic signed [31:0] gz;
        logic               sat;
    } nrm_t;

    // arctangent of 2^-idx in turns, 2^32 per turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2F9;
            15:      a = 32'h0000517C;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A2F;
            19:      a = 32'h00000517;
            20:      a = 32'h0000028B;
            21:      a = 32'h00000145;
            22:      a = 32'h000000A2;
            23:      a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // right shift rounded to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? signed'(64'(-m)) : signed'(m);
    endfunction

    // CORDIC output to Q1.FRAC_BITS, clamped to [-1, 1]
    function automatic logic signed [17:0] rnd_unit(input logic signed [33:0] v);
        logic [33:0] m;
        logic [19:0] r;
        m = v[33] ? 34'(-v) : 34'(v);
        r = 20'((m + (34'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        if (r > 20'(ONE_Q))
        begin
            r = 20'(ONE_Q);
        end
        return v[33] ? signed'(18'(-r)) : signed'(18'(r));
    endfunction

    // rounded plane product with magnitude clamp at 2^40
    function automatic logic signed [41:0] plane_term(input logic [63:0] prod, input logic neg);
        logic [63:0] r;
        r = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (r > (64'd1 << 40))
        begin
            r = 64'd1 << 40;
        end
        return neg ? signed'(42'(-r)) : signed'(42'(r));
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/terrain_height_field_eval.sv
// Terrain height-field evaluator top level: field, gradient and unit normal per position.
//
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready   | pos_x, pos_y, pos_z
//  out     | out       | out_valid / out_ready | signed_field, grad_x, grad_z, normal_*
//
// One word accepted per cycle while the output is not held; the pipeline depth is dominated by the CORDIC
// chain, the 32-step square root and the 17-step dividers.
// All stages advance together; a held output word stalls the whole pipeline.
// Reset restores register defaults and empties the pipeline. cfg_ready is always high.
module terrain_height_field_eval #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  signed_field,
    output logic signed [31:0]  grad_x,
    output logic signed [31:0]  grad_z,
    output logic signed [17:0]  normal_x,
    output logic [16:0]         normal_y,
    output logic signed [17:0]  normal_z,
    output logic                normal_valid
);

    localparam int PIPE_DEPTH = CORDIC_STAGES + thfe_pkg::FIXED_DEPTH;
    localparam int D0_IDX     = CORDIC_STAGES + 15 + thfe_pkg::SQRT_STEPS;
    localparam int SQN        = thfe_pkg::SQRT_STEPS;
    localparam int DVN        = thfe_pkg::DIV_STEPS;

    // configuration
    logic [1:0]         shape_mode_reg;
    logic signed [31:0] base_height_reg;
    logic signed [31:0] slope_x_reg;
    logic signed [31:0] slope_z_reg;
    logic [63:0]        anchor_xz_reg;
    logic signed [31:0] amplitude_reg;
    logic [31:0]        inv_wl_x_reg;
    logic [31:0]        inv_wl_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg  <= thfe_pkg::SHAPE_CONST;
            base_height_reg <= 32'sd2031616;
            slope_x_reg     <= '0;
            slope_z_reg     <= '0;
            anchor_xz_reg   <= 64'd9007199256838144;
            amplitude_reg   <= '0;
            inv_wl_x_reg    <= 32'd349525;
            inv_wl_z_reg    <= 32'd262144;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                thfe_pkg::REG_SHAPE_MODE:  shape_mode_reg  <= cfg_data[1:0];
                thfe_pkg::REG_BASE_HEIGHT: base_height_reg <= cfg_data[31:0];
                thfe_pkg::REG_SLOPE_X:     slope_x_reg     <= cfg_data[31:0];
                thfe_pkg::REG_SLOPE_Z:     slope_z_reg     <= cfg_data[31:0];
                thfe_pkg::REG_ANCHOR_XZ:   anchor_xz_reg   <= cfg_data;
                thfe_pkg::REG_AMPLITUDE:   amplitude_reg   <= cfg_data[31:0];
                thfe_pkg::REG_INV_WL_X:    inv_wl_x_reg    <= cfg_data[31:0];
                thfe_pkg::REG_INV_WL_Z:    inv_wl_z_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // values derived from configuration
    logic [63:0] kx_prod_reg, kz_prod_reg;
    logic [26:0] kx_reg, kz_reg;
    logic [31:0] msx_reg, msz_reg;
    logic        sxn_reg, szn_reg;

    always_ff @(posedge clk)
    begin
        kx_prod_reg <= 64'(inv_wl_x_reg) * 64'(thfe_pkg::TWO_PI_Q29);
        kz_prod_reg <= 64'(inv_wl_z_reg) * 64'(thfe_pkg::TWO_PI_Q29);
        kx_reg      <= 27'((kx_prod_reg + (64'd1 << (52 - thfe_pkg::FRAC_BITS)))
                           >> (53 - thfe_pkg::FRAC_BITS));
        kz_reg      <= 27'((kz_prod_reg + (64'd1 << (52 - thfe_pkg::FRAC_BITS)))
                           >> (53 - thfe_pkg::FRAC_BITS));
        msx_reg     <= slope_x_reg[31] ? 32'(-slope_x_reg) : 32'(slope_x_reg);
        msz_reg     <= slope_z_reg[31] ? 32'(-slope_z_reg) : 32'(slope_z_reg);
        sxn_reg     <= slope_x_reg[31];
        szn_reg     <= slope_z_reg[31];
    end

    // pipeline control
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;

    assign adv       = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // S1: offsets from anchor
    logic signed [32:0] s1_dx_reg, s1_dz_reg;
    logic signed [31:0] s1_py_reg;
    logic signed [32:0] s1_dx_next, s1_dz_next;

    assign s1_dx_next = {pos_x[31], pos_x} - {anchor_xz_reg[63], anchor_xz_reg[63:32]};
    assign s1_dz_next = {pos_z[31], pos_z} - {anchor_xz_reg[31], anchor_xz_reg[31:0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg <= s1_dx_next;
            s1_dz_reg <= s1_dz_next;
            s1_py_reg <= pos_y;
        end
    end

    // S2: magnitudes, phase partial products, y minus base
    logic [39:0]        dx40, dz40;
    logic [51:0]        phx_hi_full, phz_hi_full;
    logic [51:0]        s2_phx_lo_reg, s2_phz_lo_reg;
    logic [19:0]        s2_phx_hi_reg, s2_phz_hi_reg;
    logic [32:0]        s2_mdx_reg, s2_mdz_reg;
    logic               s2_ndx_reg, s2_ndz_reg;
    logic signed [33:0] s2_pyb_reg;

    assign dx40        = {{7{s1_dx_reg[32]}}, s1_dx_reg};
    assign dz40        = {{7{s1_dz_reg[32]}}, s1_dz_reg};
    assign phx_hi_full = 52'(dx40[39:20]) * 52'(inv_wl_x_reg);
    assign phz_hi_full = 52'(dz40[39:20]) * 52'(inv_wl_z_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_phx_lo_reg <= 52'(dx40[19:0]) * 52'(inv_wl_x_reg);
            s2_phz_lo_reg <= 52'(dz40[19:0]) * 52'(inv_wl_z_reg);
            s2_phx_hi_reg <= phx_hi_full[19:0];
            s2_phz_hi_reg <= phz_hi_full[19:0];
            s2_mdx_reg    <= s1_dx_reg[32] ? 33'(-s1_dx_reg) : 33'(s1_dx_reg);
            s2_mdz_reg    <= s1_dz_reg[32] ? 33'(-s1_dz_reg) : 33'(s1_dz_reg);
            s2_ndx_reg    <= s1_dx_reg[32];
            s2_ndz_reg    <= s1_dz_reg[32];
            s2_pyb_reg    <= {{2{s1_py_reg[31]}}, s1_py_reg}
                             - {{2{base_height_reg[31]}}, base_height_reg};
        end
    end

    // S3: phases in turns, plane partial products
    logic [39:0]        phx_sum, phz_sum;
    logic [31:0]        s3_phx_reg, s3_phz_reg;
    logic [47:0]        s3_ppx_lo_reg, s3_ppz_lo_reg;
    logic [48:0]        s3_ppx_hi_reg, s3_ppz_hi_reg;
    logic               s3_nx_reg, s3_nz_reg;
    logic signed [33:0] s3_pyb_reg;

    assign phx_sum = s2_phx_lo_reg[39:0] + {s2_phx_hi_reg, 20'b0};
    assign phz_sum = s2_phz_lo_reg[39:0] + {s2_phz_hi_reg, 20'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_phx_reg    <= phx_sum[39:8];
            s3_phz_reg    <= phz_sum[39:8];
            s3_ppx_lo_reg <= 48'(msx_reg) * 48'(s2_mdx_reg[15:0]);
            s3_ppz_lo_reg <= 48'(msz_reg) * 48'(s2_mdz_reg[15:0]);
            s3_ppx_hi_reg <= 49'(msx_reg) * 49'(s2_mdx_reg[32:16]);
            s3_ppz_hi_reg <= 49'(msz_reg) * 49'(s2_mdz_reg[32:16]);
            s3_nx_reg     <= sxn_reg ^ s2_ndx_reg;
            s3_nz_reg     <= szn_reg ^ s2_ndz_reg;
            s3_pyb_reg    <= s2_pyb_reg;
        end
    end

    // S4: plane terms
    logic [63:0]        prod_x, prod_z;
    logic signed [41:0] s4_tx_reg, s4_tz_reg;
    logic [31:0]        s4_phx_reg, s4_phz_reg;
    logic signed [33:0] s4_pyb_reg;

    assign prod_x = 64'(s3_ppx_lo_reg) + {s3_ppx_hi_reg[47:0], 16'b0};
    assign prod_z = 64'(s3_ppz_lo_reg) + {s3_ppz_hi_reg[47:0], 16'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_tx_reg  <= thfe_pkg::plane_term(prod_x, s3_nx_reg);
            s4_tz_reg  <= thfe_pkg::plane_term(prod_z, s3_nz_reg);
            s4_phx_reg <= s3_phx_reg;
            s4_phz_reg <= s3_phz_reg;
            s4_pyb_reg <= s3_pyb_reg;
        end
    end

    // CORDIC chain, channel a for x phase, channel b for z phase
    logic signed [33:0]  cax_reg [CORDIC_STAGES];
    logic signed [33:0]  cay_reg [CORDIC_STAGES];
    logic signed [31:0]  caz_reg [CORDIC_STAGES];
    logic signed [33:0]  cbx_reg [CORDIC_STAGES];
    logic signed [33:0]  cby_reg [CORDIC_STAGES];
    logic signed [31:0]  cbz_reg [CORDIC_STAGES];
    logic [3:0]          cq_reg  [CORDIC_STAGES];
    thfe_pkg::side_t     cside_reg [CORDIC_STAGES];

    logic signed [43:0]  fpl_wide;
    thfe_pkg::side_t     side0;

    assign fpl_wide  = 44'(s4_pyb_reg) - 44'(s4_tx_reg) - 44'(s4_tz_reg);
    assign side0.pyb = s4_pyb_reg;
    assign side0.fpl = thfe_pkg::sat32(64'(fpl_wide));

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        localparam logic signed [31:0] ATAN_K = signed'(thfe_pkg::atan_turn(k));
        logic signed [33:0] xa_in, ya_in, xb_in, yb_in;
        logic signed [31:0] za_in, zb_in;
        logic [3:0]         q_in;
        thfe_pkg::side_t    sd_in;
        logic signed [33:0] xa_next, ya_next, xb_next, yb_next;
        logic signed [31:0] za_next, zb_next;

        if (k == 0)
        begin : g_first
            assign xa_in = 34'(thfe_pkg::CORDIC_GAIN);
            assign ya_in = '0;
            assign za_in = {2'b00, s4_phx_reg[29:0]};
            assign xb_in = 34'(thfe_pkg::CORDIC_GAIN);
            assign yb_in = '0;
            assign zb_in = {2'b00, s4_phz_reg[29:0]};
            assign q_in  = {s4_phx_reg[31:30], s4_phz_reg[31:30]};
            assign sd_in = side0;
        end
        else
        begin : g_rest
            assign xa_in = cax_reg[k-1];
            assign ya_in = cay_reg[k-1];
            assign za_in = caz_reg[k-1];
            assign xb_in = cbx_reg[k-1];
            assign yb_in = cby_reg[k-1];
            assign zb_in = cbz_reg[k-1];
            assign q_in  = cq_reg[k-1];
            assign sd_in = cside_reg[k-1];
        end

        always_comb
        begin
            if (!za_in[31])
            begin
                xa_next = xa_in - (ya_in >>> k);
                ya_next = ya_in + (xa_in >>> k);
                za_next = za_in - ATAN_K;
            end
            else
            begin
                xa_next = xa_in + (ya_in >>> k);
                ya_next = ya_in - (xa_in >>> k);
                za_next = za_in + ATAN_K;
            end
            if (!zb_in[31])
            begin
                xb_next = xb_in - (yb_in >>> k);
                yb_next = yb_in + (xb_in >>> k);
                zb_next = zb_in - ATAN_K;
            end
            else
            begin
                xb_next = xb_in + (yb_in >>> k);
                yb_next = yb_in - (xb_in >>> k);
                zb_next = zb_in + ATAN_K;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cax_reg[k]   <= xa_next;
                cay_reg[k]   <= ya_next;
                caz_reg[k]   <= za_next;
                cbx_reg[k]   <= xb_next;
                cby_reg[k]   <= yb_next;
                cbz_reg[k]   <= zb_next;
                cq_reg[k]    <= q_in;
                cside_reg[k] <= sd_in;
            end
        end
    end

    // R1: round and clamp; R2: quadrant mapping
    logic signed [17:0] r1_cra_reg, r1_sra_reg, r1_crb_reg, r1_srb_reg;
    logic [3:0]         r1_q_reg;
    thfe_pkg::side_t    r1_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_cra_reg  <= thfe_pkg::rnd_unit(cax_reg[CORDIC_STAGES-1]);
            r1_sra_reg  <= thfe_pkg::rnd_unit(cay_reg[CORDIC_STAGES-1]);
            r1_crb_reg  <= thfe_pkg::rnd_unit(cbx_reg[CORDIC_STAGES-1]);
            r1_srb_reg  <= thfe_pkg::rnd_unit(cby_reg[CORDIC_STAGES-1]);
            r1_q_reg    <= cq_reg[CORDIC_STAGES-1];
            r1_side_reg <= cside_reg[CORDIC_STAGES-1];
        end
    end

    logic signed [17:0] cx_next, sx_next, cz_next, sz_next;

    always_comb
    begin
        case (r1_q_reg[3:2])
            2'd0:    begin cx_next = r1_cra_reg;  sx_next = r1_sra_reg;  end
            2'd1:    begin cx_next = -r1_sra_reg; sx_next = r1_cra_reg;  end
            2'd2:    begin cx_next = -r1_cra_reg; sx_next = -r1_sra_reg; end
            default: begin cx_next = r1_sra_reg;  sx_next = -r1_cra_reg; end
        endcase
        case (r1_q_reg[1:0])
            2'd0:    begin cz_next = r1_crb_reg;  sz_next = r1_srb_reg;  end
            2'd1:    begin cz_next = -r1_srb_reg; sz_next = r1_crb_reg;  end
            2'd2:    begin cz_next = -r1_crb_reg; sz_next = -r1_srb_reg; end
            default: begin cz_next = r1_srb_reg;  sz_next = -r1_crb_reg; end
        endcase
    end

    logic signed [17:0] r2_cx_reg, r2_sx_reg, r2_cz_reg, r2_sz_reg;
    thfe_pkg::side_t    r2_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_cx_reg   <= cx_next;
            r2_sx_reg   <= sx_next;
            r2_cz_reg   <= cz_next;
            r2_sz_reg   <= sz_next;
            r2_side_reg <= r1_side_reg;
        end
    end

    // M1..M6: wave products
    logic signed [35:0] m1_p1_reg, m1_p2_reg, m1_p3_reg;
    thfe_pkg::side_t    m1_side_reg;
    logic signed [17:0] m2_m1_reg, m2_m2_reg, m2_m3_reg;
    thfe_pkg::side_t    m2_side_reg;
    logic signed [49:0] m3_pa_reg;
    logic signed [45:0] m3_pk2_reg, m3_pk3_reg;
    thfe_pkg::side_t    m3_side_reg;
    logic signed [32:0] m4_h_reg;
    logic signed [28:0] m4_t1_reg, m4_t2_reg;
    thfe_pkg::side_t    m4_side_reg;
    logic signed [60:0] m5_pg1_reg, m5_pg2_reg;
    logic signed [34:0] m5_fper_reg;
    thfe_pkg::side_t    m5_side_reg;
    logic signed [44:0] m6_gx_reg, m6_gz_reg;
    logic signed [34:0] m6_fper_reg;
    thfe_pkg::side_t    m6_side_reg;

    logic signed [63:0] m2_r1, m2_r2, m2_r3, m4_rh, m4_r1, m4_r2, m6_r1, m6_r2;

    assign m2_r1 = thfe_pkg::rnd_shr(64'(m1_p1_reg), thfe_pkg::FRAC_BITS);
    assign m2_r2 = thfe_pkg::rnd_shr(64'(m1_p2_reg), thfe_pkg::FRAC_BITS);
    assign m2_r3 = thfe_pkg::rnd_shr(64'(m1_p3_reg), thfe_pkg::FRAC_BITS);
    assign m4_rh = thfe_pkg::rnd_shr(64'(m3_pa_reg), thfe_pkg::FRAC_BITS);
    assign m4_r1 = thfe_pkg::rnd_shr(64'(m3_pk2_reg), thfe_pkg::FRAC_BITS);
    assign m4_r2 = thfe_pkg::rnd_shr(64'(m3_pk3_reg), thfe_pkg::FRAC_BITS);
    assign m6_r1 = thfe_pkg::rnd_shr(64'(m5_pg1_reg), thfe_pkg::FRAC_BITS);
    assign m6_r2 = thfe_pkg::rnd_shr(64'(m5_pg2_reg), thfe_pkg::FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_p1_reg   <= r2_sx_reg * r2_cz_reg;
            m1_p2_reg   <= r2_cx_reg * r2_cz_reg;
            m1_p3_reg   <= r2_sx_reg * r2_sz_reg;
            m1_side_reg <= r2_side_reg;

            m2_m1_reg   <= m2_r1[17:0];
            m2_m2_reg   <= m2_r2[17:0];
            m2_m3_reg   <= m2_r3[17:0];
            m2_side_reg <= m1_side_reg;

            m3_pa_reg   <= amplitude_reg * m2_m1_reg;
            m3_pk2_reg  <= signed'({1'b0, kx_reg}) * m2_m2_reg;
            m3_pk3_reg  <= signed'({1'b0, kz_reg}) * m2_m3_reg;
            m3_side_reg <= m2_side_reg;

            m4_h_reg    <= m4_rh[32:0];
            m4_t1_reg   <= m4_r1[28:0];
            m4_t2_reg   <= m4_r2[28:0];
            m4_side_reg <= m3_side_reg;

            m5_pg1_reg  <= amplitude_reg * m4_t1_reg;
            m5_pg2_reg  <= amplitude_reg * m4_t2_reg;
            m5_fper_reg <= 35'(m4_side_reg.pyb) - 35'(m4_h_reg);
            m5_side_reg <= m4_side_reg;

            m6_gx_reg   <= 45'(-m6_r1);
            m6_gz_reg   <= m6_r2[44:0];
            m6_fper_reg <= m5_fper_reg;
            m6_side_reg <= m5_side_reg;
        end
    end

    // E: shape select and saturation
    logic signed [63:0] fsel, gxsel, gzsel;
    thfe_pkg::nrm_t     e_next, e_reg;

    always_comb
    begin
        case (shape_mode_reg)
            thfe_pkg::SHAPE_PLANE:
            begin
                fsel  = 64'(m6_side_reg.fpl);
                gxsel = -64'(slope_x_reg);
                gzsel = -64'(slope_z_reg);
            end
            thfe_pkg::SHAPE_PERIODIC:
            begin
                fsel  = 64'(m6_fper_reg);
                gxsel = 64'(m6_gx_reg);
                gzsel = 64'(m6_gz_reg);
            end
            default:
            begin
                fsel  = 64'(m6_side_reg.pyb);
                gxsel = '0;
                gzsel = '0;
            end
        endcase
        e_next.field = thfe_pkg::sat32(fsel);
        e_next.gx    = thfe_pkg::sat32(gxsel);
        e_next.gz    = thfe_pkg::sat32(gzsel);
        e_next.sat   = thfe_pkg::ovf32(gxsel) || thfe_pkg::ovf32(gzsel);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg <= e_next;
        end
    end

    // N1: squares; N2: sum of squares plus one
    logic [31:0]    e_mgx, e_mgz;
    logic [63:0]    n1_sqx_reg, n1_sqz_reg;
    thfe_pkg::nrm_t n1_reg, n2_reg;
    logic [63:0]    n2_sum_reg;

    assign e_mgx = e_reg.gx[31] ? 32'(-e_reg.gx) : 32'(e_reg.gx);
    assign e_mgz = e_reg.gz[31] ? 32'(-e_reg.gz) : 32'(e_reg.gz);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_sqx_reg <= 64'(e_mgx) * 64'(e_mgx);
            n1_sqz_reg <= 64'(e_mgz) * 64'(e_mgz);
            n1_reg     <= e_reg;
            n2_sum_reg <= n1_sqx_reg + n1_sqz_reg
                          + (thfe_pkg::ONE_Q * thfe_pkg::ONE_Q);
            n2_reg     <= n1_reg;
        end
    end

    // square root, one result bit per stage
    logic [63:0]    sq_v_reg [SQN];
    logic [63:0]    sq_r_reg [SQN];
    thfe_pkg::nrm_t sq_n_reg [SQN];

    for (genvar i = 0; i < SQN; i++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0]    v_in, r_in, trial, v_next, r_next;
        thfe_pkg::nrm_t n_in;

        if (i == 0)
        begin : g_first
            assign v_in = n2_sum_reg;
            assign r_in = '0;
            assign n_in = n2_reg;
        end
        else
        begin : g_rest
            assign v_in = sq_v_reg[i-1];
            assign r_in = sq_r_reg[i-1];
            assign n_in = sq_n_reg[i-1];
        end

        assign trial = r_in + BIT;

        always_comb
        begin
            if (v_in >= trial)
            begin
                v_next = v_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_v_reg[i] <= v_next;
                sq_r_reg[i] <= r_next;
                sq_n_reg[i] <= n_in;
            end
        end
    end

    // D0: rounded numerators
    logic [32:0]    sq_len;
    logic [31:0]    sq_mgx, sq_mgz;
    logic [32:0]    d0_len_reg;
    logic [49:0]    d0_nx_reg, d0_ny_reg, d0_nz_reg;
    thfe_pkg::nrm_t d0_n_reg;

    assign sq_len = sq_r_reg[SQN-1][32:0];
    assign sq_mgx = sq_n_reg[SQN-1].gx[31] ? 32'(-sq_n_reg[SQN-1].gx)
                                           : 32'(sq_n_reg[SQN-1].gx);
    assign sq_mgz = sq_n_reg[SQN-1].gz[31] ? 32'(-sq_n_reg[SQN-1].gz)
                                           : 32'(sq_n_reg[SQN-1].gz);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_len_reg <= sq_len;
            d0_nx_reg  <= (50'(sq_mgx) << thfe_pkg::FRAC_BITS) + 50'(sq_len >> 1);
            d0_ny_reg  <= (50'(thfe_pkg::ONE_Q) << thfe_pkg::FRAC_BITS) + 50'(sq_len >> 1);
            d0_nz_reg  <= (50'(sq_mgz) << thfe_pkg::FRAC_BITS) + 50'(sq_len >> 1);
            d0_n_reg   <= sq_n_reg[SQN-1];
        end
    end

    // restoring dividers, quotient MSB first
    logic [49:0]    dv_rx_reg [DVN];
    logic [49:0]    dv_ry_reg [DVN];
    logic [49:0]    dv_rz_reg [DVN];
    logic [16:0]    dv_qx_reg [DVN];
    logic [16:0]    dv_qy_reg [DVN];
    logic [16:0]    dv_qz_reg [DVN];
    logic [32:0]    dv_len_reg [DVN];
    thfe_pkg::nrm_t dv_n_reg [DVN];

    for (genvar j = 0; j < DVN; j++)
    begin : g_div
        localparam int SH = DVN - 1 - j;
        logic [49:0]    rx_in, ry_in, rz_in, dsh;
        logic [16:0]    qx_in, qy_in, qz_in;
        logic [32:0]    len_in;
        thfe_pkg::nrm_t n_in;
        logic           gex, gey, gez;

        if (j == 0)
        begin : g_first
            assign rx_in  = d0_nx_reg;
            assign ry_in  = d0_ny_reg;
            assign rz_in  = d0_nz_reg;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign qz_in  = '0;
            assign len_in = d0_len_reg;
            assign n_in   = d0_n_reg;
        end
        else
        begin : g_rest
            assign rx_in  = dv_rx_reg[j-1];
            assign ry_in  = dv_ry_reg[j-1];
            assign rz_in  = dv_rz_reg[j-1];
            assign qx_in  = dv_qx_reg[j-1];
            assign qy_in  = dv_qy_reg[j-1];
            assign qz_in  = dv_qz_reg[j-1];
            assign len_in = dv_len_reg[j-1];
            assign n_in   = dv_n_reg[j-1];
        end

        assign dsh = 50'(len_in) << SH;
        assign gex = rx_in >= dsh;
        assign gey = ry_in >= dsh;
        assign gez = rz_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rx_reg[j]  <= gex ? rx_in - dsh : rx_in;
                dv_ry_reg[j]  <= gey ? ry_in - dsh : ry_in;
                dv_rz_reg[j]  <= gez ? rz_in - dsh : rz_in;
                dv_qx_reg[j]  <= {qx_in[15:0], gex};
                dv_qy_reg[j]  <= {qy_in[15:0], gey};
                dv_qz_reg[j]  <= {qz_in[15:0], gez};
                dv_len_reg[j] <= len_in;
                dv_n_reg[j]   <= n_in;
            end
        end
    end

    // output word
    thfe_pkg::nrm_t     fin;
    logic signed [17:0] nx_next, nz_next;
    logic [16:0]        ny_next;

    assign fin = dv_n_reg[DVN-1];

    always_comb
    begin
        if (fin.sat)
        begin
            nx_next = '0;
            ny_next = '0;
            nz_next = '0;
        end
        else
        begin
            nx_next = fin.gx[31] ? -signed'({1'b0, dv_qx_reg[DVN-1]})
                                 : signed'({1'b0, dv_qx_reg[DVN-1]});
            ny_next = dv_qy_reg[DVN-1];
            nz_next = fin.gz[31] ? -signed'({1'b0, dv_qz_reg[DVN-1]})
                                 : signed'({1'b0, dv_qz_reg[DVN-1]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            signed_field <= fin.field;
            grad_x       <= fin.gx;
            grad_z       <= fin.gz;
            normal_x     <= nx_next;
            normal_y     <= ny_next;
            normal_z     <= nz_next;
            normal_valid <= !fin.sat;
        end
    end

    // checks
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_bad_normal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !normal_valid |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("normal not cleared on saturated gradient");

    a_normal_y_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && normal_valid |-> normal_y != 0)
        else $error("zero normal y on valid normal");

    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[D0_IDX] |-> d0_len_reg >= 33'(thfe_pkg::ONE_Q))
        else $error("gradient length below one");

endmodule
